FILE: rtl/mau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types and command codes of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned MW = 30;
  localparam int unsigned EW = 63;
  localparam int unsigned WW = 64;
  localparam logic [MW-1:0] MOD_RESET = MW'(998244353);

  typedef enum logic [3:0] {
    CMD_REDUCE = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_MUL    = 4'd3,
    CMD_DIV    = 4'd4,
    CMD_POW    = 4'd5,
    CMD_INV    = 4'd6,
    CMD_REM    = 4'd7,
    CMD_INC    = 4'd8,
    CMD_DEC    = 4'd9,
    CMD_CMP    = 4'd10
  } cmd_e;

  typedef struct packed {
    logic [3:0]    cmd;
    logic [MW-1:0] operand_a;
    logic [MW-1:0] operand_b;
    logic [EW-1:0] exponent;
    logic [WW-1:0] wide_value;
  } req_t;

  typedef struct packed {
    logic [MW-1:0] result;
    logic          less;
    logic          equal;
    logic          error;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_WIDE,
    ST_MUL,
    ST_POW,
    ST_POW2,
    ST_DIVMUL,
    ST_REM,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/modular_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Sequenced modular arithmetic over a configured prime modulus.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start_i with a request on req_i while busy_o is low; the request is
//   taken at that edge and busy_o rises. One response appears on rsp_o with
//   done_o high for exactly one cycle; the receiver cannot stall it.
//   Write the modulus through cfg_we_i / cfg_wdata_i while idle.
// Datapath:
//   One shared restoring reduction unit (one quotient bit per cycle) serves
//   every modulo step: operand reduction, products, wide reduce and remainder.
//   A product a*b (2*MOD_WIDTH bits) is reduced by the same unit.
// Sequence after the accept edge:
//   sub/inc/dec/compare: operand reduction only.
//   add, mul, remainder by a nonzero divisor: operand reduction, then one
//   more pass of the unit. reduce: operand reduction, then a 64-bit pass.
//   pow/inverse/div: up to two products per exponent bit, each reduced by
//   the unit in turn; div ends with one more product.
// Throughput: the next request can be taken in the cycle done_o is high.
// Reset: modulus returns to 998244353, the sequencer goes idle.
// ----------------------------------------------------------------------------
module modular_arithmetic_unit (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  wire mau_pkg::req_t       req_i,
  output logic                     busy_o,
  output logic                     done_o,
  output mau_pkg::rsp_t            rsp_o,
  input  wire                      cfg_we_i,
  input  wire [mau_pkg::MW-1:0]    cfg_wdata_i
);
  import mau_pkg::*;

  localparam int unsigned MOD_WIDTH = MW;
  localparam int unsigned EXP_WIDTH = EW;
  localparam int unsigned PW = 2 * MOD_WIDTH;   // product width
  localparam int unsigned DW = (PW > 64) ? PW : 64; // dividend register width
  localparam int unsigned CW = $clog2(DW + 1);

  logic [MOD_WIDTH-1:0] mod_q;
  state_e state_q, state_d;

  // request copy
  logic [3:0]           cmd_q;
  logic [EXP_WIDTH-1:0] exp_q, exp_d;
  logic [63:0]          wide_q;
  logic [MOD_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [MOD_WIDTH-1:0] acc_q, acc_d, sq_q, sq_d;
  logic                 neg_q;

  // shared reduction unit: remainder register and dividend shifter
  logic [DW-1:0]        div_q, div_d;
  logic [MOD_WIDTH:0]   rem_q, rem_d;
  logic [MOD_WIDTH-1:0] dvs_q, dvs_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 pstep_q, pstep_d;  // pow: 0 = multiply acc, 1 = square

  rsp_t rsp_d, rsp_q;
  logic done_d;

  logic [MOD_WIDTH-1:0] m_eff;
  logic [MOD_WIDTH:0]   shifted, trial;
  logic                 ge;

  assign m_eff   = (mod_q == '0) ? MOD_WIDTH'(1) : mod_q;
  assign shifted = {rem_q[MOD_WIDTH-1:0], div_q[DW-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= MOD_WIDTH'(MOD_RESET);
      state_q <= ST_IDLE;
      done_o  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
      state_q <= state_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      cmd_q  <= req_i.cmd;
      wide_q <= req_i.wide_value;
      neg_q  <= req_i.wide_value[63];
    end
    exp_q   <= exp_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    sq_q    <= sq_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    cnt_q   <= cnt_d;
    pstep_q <= pstep_d;
    rsp_q   <= rsp_d;
  end

  assign rsp_o  = rsp_q;
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    exp_d   = exp_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    sq_d    = sq_q;
    div_d   = div_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    pstep_d = pstep_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;

    // one restoring step of the shared unit whenever a count is running
    if (cnt_q != '0) begin
      div_d = {div_q[DW-2:0], 1'b0};
      rem_d = ge ? trial : shifted;
      cnt_d = cnt_q - CW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a_d     = req_i.operand_a;
          b_d     = req_i.operand_b;
          exp_d   = req_i.exponent[EXP_WIDTH-1:0];
          div_d   = {req_i.operand_a, {(DW-MOD_WIDTH){1'b0}}};
          rem_d   = '0;
          dvs_d   = m_eff;
          cnt_d   = CW'(MOD_WIDTH);
          state_d = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (cnt_q == '0) begin
          a_d     = rem_q[MOD_WIDTH-1:0];
          div_d   = {b_q, {(DW-MOD_WIDTH){1'b0}}};
          rem_d   = '0;
          cnt_d   = CW'(MOD_WIDTH);
          state_d = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (cnt_q == '0) begin
          b_d     = rem_q[MOD_WIDTH-1:0];
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        rsp_d   = '0;
        state_d = ST_DONE;
        case (cmd_q)
          CMD_REDUCE: begin
            div_d   = DW'(neg_q ? (~wide_q + 64'd1) : wide_q) << (DW - 64);
            rem_d   = '0;
            cnt_d   = CW'(64);
            state_d = ST_WIDE;
          end
          CMD_ADD: begin
            div_d   = DW'({1'b0, a_q} + {1'b0, b_q}) << (DW - MOD_WIDTH - 1);
            rem_d   = '0;
            cnt_d   = CW'(MOD_WIDTH + 1);
            state_d = ST_REM;
          end
          CMD_SUB: begin
            rsp_d.result = (a_q >= b_q) ? (a_q - b_q) : (a_q + m_eff - b_q);
            if (rsp_d.result == m_eff) rsp_d.result = '0;
          end
          CMD_MUL: begin
            acc_d   = a_q;
            sq_d    = b_q;
            div_d   = DW'(PW'(a_q) * PW'(b_q)) << (DW - PW);
            rem_d   = '0;
            cnt_d   = CW'(PW);
            state_d = ST_MUL;
          end
          CMD_DIV, CMD_POW, CMD_INV: begin
            if (cmd_q == CMD_POW) begin
              sq_d = a_q;
            end else begin
              sq_d  = (cmd_q == CMD_DIV) ? b_q : a_q;
              exp_d = (m_eff >= MOD_WIDTH'(2)) ? EXP_WIDTH'(m_eff - MOD_WIDTH'(2))
                                               : '0;
            end
            acc_d   = (m_eff == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
            pstep_d = 1'b0;
            state_d = ST_POW;
          end
          CMD_REM: begin
            if (b_q == '0) begin
              rsp_d.error = 1'b1;
            end else begin
              div_d   = {a_q, {(DW-MOD_WIDTH){1'b0}}};
              rem_d   = '0;
              dvs_d   = b_q;
              cnt_d   = CW'(MOD_WIDTH);
              state_d = ST_REM;
            end
          end
          CMD_INC: begin
            rsp_d.result = ({1'b0, a_q} + 1'b1 >= {1'b0, m_eff}) ? '0 : a_q + 1'b1;
          end
          CMD_DEC: begin
            rsp_d.result = (a_q == '0) ? m_eff - 1'b1 : a_q - 1'b1;
          end
          CMD_CMP: begin
            rsp_d.less  = (a_q < b_q);
            rsp_d.equal = (a_q == b_q);
          end
          default: ;
        endcase
      end
      ST_WIDE: begin
        if (cnt_q == '0) begin
          rsp_d.result = (neg_q && rem_q != '0) ? m_eff - rem_q[MOD_WIDTH-1:0]
                                                : rem_q[MOD_WIDTH-1:0];
          state_d = ST_DONE;
        end
      end
      ST_MUL, ST_REM: begin
        if (cnt_q == '0) begin
          rsp_d.result = rem_q[MOD_WIDTH-1:0];
          state_d = ST_DONE;
        end
      end
      ST_POW: begin
        // pick next product: acc*sq when the low bit is set, then sq*sq
        if (exp_q == '0) begin
          if (cmd_q == CMD_DIV) begin
            div_d   = DW'(PW'(a_q) * PW'(acc_q)) << (DW - PW);
            rem_d   = '0;
            cnt_d   = CW'(PW);
            state_d = ST_MUL;
          end else begin
            rsp_d.result = acc_q;
            state_d = ST_DONE;
          end
        end else if (!pstep_q && exp_q[0]) begin
          div_d   = DW'(PW'(acc_q) * PW'(sq_q)) << (DW - PW);
          rem_d   = '0;
          cnt_d   = CW'(PW);
          state_d = ST_POW2;
        end else begin
          pstep_d = 1'b1;
          div_d   = DW'(PW'(sq_q) * PW'(sq_q)) << (DW - PW);
          rem_d   = '0;
          cnt_d   = CW'(PW);
          state_d = ST_POW2;
        end
      end
      ST_POW2: begin
        if (cnt_q == '0) begin
          if (!pstep_q && exp_q[0]) begin
            acc_d   = rem_q[MOD_WIDTH-1:0];
            pstep_d = 1'b1;
          end else begin
            sq_d    = rem_q[MOD_WIDTH-1:0];
            exp_d   = exp_q >> 1;
            pstep_d = 1'b0;
          end
          state_d = ST_POW;
        end
      end
      ST_DONE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held for two cycles");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.result < m_eff || rsp_o.result == '0))
    else $error("result not below modulus");
  a_flags_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(rsp_o.less && rsp_o.equal)) else $error("less and equal both set");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_modular_arithmetic_unit.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_modular_arithmetic_unit
// Self-checking bench for the modular arithmetic unit. Each command that has
// no typed answer in the table is computed again with 64-bit integer math
// at the configured modulus. Each response is compared field by field with
// the oldest answer still owed. The run walks a table of hand-picked commands,
// then random commands over a series of moduli that includes zero, one, two
// and the largest value, with several patterns of gaps between requests.
// ----------------------------------------------------------------------------
module tb_modular_arithmetic_unit;
  import mau_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 30_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t rs;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  req_t          req_i = '0;
  logic          busy_o;
  logic          done_o;
  rsp_t          rsp_o;
  logic          cfg_we_i = 1'b0;
  logic [MW-1:0] cfg_wdata_i = '0;

  rsp_t            expected_answers[$];
  logic [MW-1:0]   modulus_q = MOD_RESET;
  int unsigned     mismatches = 0;
  longint unsigned cycles = 0;
  int unsigned     gap_pct = 0;
  row_t            table_rows[$];

  modular_arithmetic_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned mul_mod(longint unsigned x, longint unsigned y,
                                              longint unsigned m);
    return (x * y) % m;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    acc = 1 % m;
    sq  = base % m;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic rsp_t compute_answer(req_t r);
    longint unsigned m;
    longint unsigned a;
    longint unsigned b;
    longint unsigned w;
    longint unsigned rem;
    longint unsigned res;
    rsp_t o;
    m   = (modulus_q == 0) ? 1 : 64'(modulus_q);
    a   = 64'(r.operand_a) % m;
    b   = 64'(r.operand_b) % m;
    w   = r.wide_value;
    res = 0;
    o   = '0;
    case (cmd_e'(r.cmd))
      CMD_REDUCE: begin
        if (w[63]) begin
          rem = (~w + 1) % m;
          res = (rem != 0) ? m - rem : 0;
        end else begin
          res = w % m;
        end
      end
      CMD_ADD: res = (a + b) % m;
      CMD_SUB: res = (a + m - b) % m;
      CMD_MUL: res = mul_mod(a, b, m);
      CMD_DIV: res = mul_mod(a, pow_mod(b, (m >= 2) ? m - 2 : 0, m), m);
      CMD_POW: res = pow_mod(a, 64'(r.exponent), m);
      CMD_INV: res = pow_mod(a, (m >= 2) ? m - 2 : 0, m);
      CMD_REM: begin
        if (b == 0) o.error = 1'b1;
        else res = a % b;
      end
      CMD_INC: res = (a + 1 >= m) ? 0 : a + 1;
      CMD_DEC: res = (a == 0) ? m - 1 : a - 1;
      CMD_CMP: begin
        o.less  = (a < b);
        o.equal = (a == b);
      end
      default: res = 0;
    endcase
    o.result = res[MW-1:0];
    return o;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // response checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_answers.size() == 0) begin
        report("unexpected transaction, result", rsp_o.result, 0);
      end else begin
        want = expected_answers.pop_front();
        if (rsp_o.result !== want.result) report("result", rsp_o.result, want.result);
        if (rsp_o.less !== want.less) report("less", rsp_o.less, want.less);
        if (rsp_o.equal !== want.equal) report("equal", rsp_o.equal, want.equal);
        if (rsp_o.error !== want.error) report("error", rsp_o.error, want.error);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one transaction and hold it until accepted
  task automatic send(req_t r, bit typed, rsp_t typed_rsp);
    bit taken;
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    do begin
      @(posedge clk_i);
      taken = !busy_o;
    end while (!taken);
    expected_answers.push_back(typed ? typed_rsp : compute_answer(r));
  endtask

  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  task automatic drain();
    idle(1);
    while (expected_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_modulus(logic [MW-1:0] v);
    drain();
    idle(4);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    modulus_q = v;
  endtask

  function automatic row_t row(cmd_e c, longint unsigned a, longint unsigned b,
                               longint unsigned e, longint unsigned w, bit typed,
                               longint unsigned res, bit lt, bit eq, bit er);
    row_t t;
    t.rq.cmd        = c;
    t.rq.operand_a  = a[MW-1:0];
    t.rq.operand_b  = b[MW-1:0];
    t.rq.exponent   = e[EW-1:0];
    t.rq.wide_value = w;
    t.typed         = typed;
    t.rs.result     = res[MW-1:0];
    t.rs.less       = lt;
    t.rs.equal      = eq;
    t.rs.error      = er;
    return t;
  endfunction

  function automatic logic [MW-1:0] pick_operand();
    logic [MW-1:0] m;
    m = modulus_q;
    case ($urandom_range(3))
      0: return MW'($urandom);
      1: return MW'($urandom_range(7));
      2: return m - MW'($urandom_range(3));
      default: return m + MW'($urandom_range(3));
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.cmd        = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                              : 4'($urandom_range(10));
    r.operand_a  = pick_operand();
    r.operand_b  = ($urandom_range(9) == 0) ? '0 : pick_operand();
    // long exponents are slow, so most stay short
    if ($urandom_range(9) == 0) r.exponent = EW'({$urandom, $urandom});
    else r.exponent = EW'($urandom_range(16'hffff) >> $urandom_range(16));
    r.wide_value = {$urandom, $urandom};
    if ($urandom_range(7) == 0) r.wide_value = $urandom_range(1) ? 64'h8000_0000_0000_0000
                                                                  : 64'h7fff_ffff_ffff_ffff;
    return r;
  endfunction

  initial begin
    logic [MW-1:0] moduli[$];
    longint unsigned mr;
    longint unsigned top;
    rsp_t none;

    mr  = 998244353;
    top = 64'h3fff_ffff;
    none = '0;
    table_rows.push_back(row(CMD_REDUCE, 0, 0, 0, '1, 1, mr - 1, 0, 0, 0));
    table_rows.push_back(row(CMD_REDUCE, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_REDUCE, 0, 0, 0, 64'h7fff_ffff_ffff_ffff, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_REDUCE, 0, 0, 0, mr, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_ADD, mr - 1, 1, 0, 0, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_ADD, top, top, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_SUB, 0, 1, 0, 0, 1, mr - 1, 0, 0, 0));
    table_rows.push_back(row(CMD_MUL, mr - 1, mr - 1, 0, 0, 1, 1, 0, 0, 0));
    table_rows.push_back(row(CMD_MUL, top, top, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_DIV, 5, 0, 0, 0, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_DIV, 6, 3, 0, 0, 1, 2, 0, 0, 0));
    table_rows.push_back(row(CMD_POW, 12345, 0, 0, 0, 1, 1, 0, 0, 0));
    table_rows.push_back(row(CMD_POW, 3, 0, '1, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_INV, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_INV, 1, 0, 0, 0, 1, 1, 0, 0, 0));
    table_rows.push_back(row(CMD_REM, 17, 0, 0, 0, 1, 0, 0, 0, 1));
    table_rows.push_back(row(CMD_REM, 17, mr, 0, 0, 1, 0, 0, 0, 1));
    table_rows.push_back(row(CMD_REM, 17, 5, 0, 0, 1, 2, 0, 0, 0));
    table_rows.push_back(row(CMD_INC, mr - 1, 0, 0, 0, 1, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_INC, top, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(row(CMD_DEC, 0, 0, 0, 0, 1, mr - 1, 0, 0, 0));
    table_rows.push_back(row(CMD_CMP, 5, mr + 5, 0, 0, 1, 0, 0, 1, 0));
    table_rows.push_back(row(CMD_CMP, 3, 7, 0, 0, 1, 0, 1, 0, 0));
    table_rows.push_back(row(cmd_e'(4'hb), 9, 9, 9, 9, 1, 0, 0, 0, 0));
    table_rows.push_back(row(cmd_e'(4'hf), top, top, '1, '1, 1, 0, 0, 0, 0));

    moduli = '{30'd1000000007, 30'd3, 30'h3fff_ffff, 30'd2, 30'd1, 30'd0, 30'd7,
               30'd65537, 30'd1073741789, 30'h2aaa_aaab, 30'd998244353};

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) send(table_rows[i].rq, table_rows[i].typed, table_rows[i].rs);

    foreach (moduli[p]) begin
      write_modulus(moduli[p]);
      case (p % 3)
        0: gap_pct = 0;
        1: gap_pct = 61;
        default: gap_pct = 6;
      endcase
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain();
        if ($urandom_range(99) < gap_pct) idle($urandom_range(1, 6));
        send(random_request(), 1'b0, none);
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: modular_arithmetic_unit.f
rtl/mau_pkg.sv
rtl/modular_arithmetic_unit.sv
tb/tb_modular_arithmetic_unit.sv
